// ----- rtl/rpn_pkg.sv -----
`default_nettype none

package rpn_pkg;

	// expression characters
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_PLUS   = 8'd43;
	localparam logic [7:0] CH_MINUS  = 8'd45;
	localparam logic [7:0] CH_TIMES  = 8'd42;
	localparam logic [7:0] CH_DIVIDE = 8'd47;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_UNDER   = 2'd1;
	localparam logic [1:0] STATUS_OVER    = 2'd2;
	localparam logic [1:0] STATUS_DIVZERO = 2'd3;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_PUSH = 10'b00_0000_0010,
		ST_RB   = 10'b00_0000_0100,
		ST_RA   = 10'b00_0000_1000,
		ST_EXEC = 10'b00_0001_0000,
		ST_DIV  = 10'b00_0010_0000,
		ST_DIVW = 10'b00_0100_0000,
		ST_FIN  = 10'b00_1000_0000,
		ST_FRD  = 10'b01_0000_0000,
		ST_EMIT = 10'b10_0000_0000
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/rpn_ram.sv -----
`default_nettype none

module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/rpn_stack_calculator.sv -----
// sequence: a digit that is not last stays in idle; any other character passes through push;
// an operator then passes rb, ra and exec; divide adds a 32-step divider and divw
// throughput: one character at a time, bounded by the stack ram read sequence and the divider
// the last character then passes fin and frd (top-of-stack read) before the result is offered
// reset: arst_n low clears the sequencer, stack count, number and error state at once;
// the stack ram holds no reset and is only read below the stack count
`default_nettype none

module rpn_stack_calculator #(
	parameter int STACK_DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	// character channel
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [7:0]         char_code,
	input  wire                last,
	// result channel
	output logic               out_valid,
	input  wire                out_stall,
	output logic signed [31:0] value,
	output logic [1:0]         status
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int DW     = rpn_pkg::DATA_W;

	rpn_pkg::state_t state_q;

	// stack and number state
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    acc_q;
	logic             in_number_q;
	logic [1:0]       err_q;

	// latched character of the current transfer
	logic [7:0]       ch_q;
	logic             last_q;

	// operands and result holding
	logic [DW-1:0]    b_q;
	logic [DW-1:0]    val_q;

	// divider
	logic [DW-1:0]    div_rem_q;
	logic [DW-1:0]    div_quo_q;
	logic [DW-1:0]    div_den_q;
	logic [4:0]       div_cnt_q;
	logic             div_neg_q;

	// output register
	logic             out_valid_q;
	logic [DW-1:0]    value_q;
	logic [1:0]       status_q;

	// stack ram port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DW-1:0]     ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DW-1:0]     ram_rdata;

	logic             in_digit;
	logic             q_digit;
	logic             q_op;
	logic             full;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_m2;
	logic [CNT_W-1:0] cnt_pu;
	logic [DW-1:0]    acc_nxt;
	logic [DW-1:0]    alu_res;
	logic             alu_wr;
	logic [DW-1:0]    a_mag;
	logic [DW-1:0]    b_mag;
	logic [DW:0]      div_sh;
	logic [DW:0]      div_diff;
	logic             div_ge;
	logic [DW-1:0]    quo_res;
	logic             out_free;

	// character classes
	always_comb begin
		in_digit = char_code inside {[rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]};
		q_digit  = ch_q inside {[rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]};
		q_op     = !q_digit && (ch_q != rpn_pkg::CH_SPACE);
	end

	// decimal accumulate: acc*10 + digit, wrapping at 32 bits
	assign acc_nxt = {acc_q[DW-4:0], 3'b000} + {acc_q[DW-2:0], 1'b0}
		+ {{(DW-4){1'b0}}, char_code[3:0]};

	assign full   = (cnt_q >= CNT_W'(STACK_DEPTH));
	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign cnt_m2 = cnt_q - CNT_W'(2);
	// stack count after the pending number is pushed
	assign cnt_pu = (in_number_q && !full) ? cnt_q + CNT_W'(1) : cnt_q;

	// operator unit: a comes straight from the ram read port, b was read in the cycle before
	always_comb begin
		alu_res = '0;
		alu_wr  = 1'b0;
		case (ch_q)
			rpn_pkg::CH_PLUS: begin
				alu_res = ram_rdata + b_q;
				alu_wr  = 1'b1;
			end
			rpn_pkg::CH_MINUS: begin
				alu_res = ram_rdata - b_q;
				alu_wr  = 1'b1;
			end
			rpn_pkg::CH_TIMES: begin
				alu_res = ram_rdata * b_q;
				alu_wr  = 1'b1;
			end
			default: begin
				alu_res = '0;
				alu_wr  = 1'b0;
			end
		endcase
	end

	// operand magnitudes for the divider
	assign a_mag = ram_rdata[DW-1] ? (~ram_rdata + DW'(1)) : ram_rdata;
	assign b_mag = b_q[DW-1] ? (~b_q + DW'(1)) : b_q;

	// one restoring division step per cycle
	assign div_sh   = {div_rem_q, div_quo_q[DW-1]};
	assign div_diff = div_sh - {1'b0, div_den_q};
	assign div_ge   = !div_diff[DW];
	// truncation toward zero: negate the magnitude quotient when signs differ
	assign quo_res  = div_neg_q ? (~div_quo_q + DW'(1)) : div_quo_q;

	assign out_free = !out_valid_q || !out_stall;

	// stack ram access by sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = acc_q;
		ram_raddr = cnt_m1[ADDR_W-1:0];
		case (state_q)
			rpn_pkg::ST_PUSH: begin
				ram_we = in_number_q && !full;
			end
			rpn_pkg::ST_RA: begin
				ram_raddr = cnt_m2[ADDR_W-1:0];
			end
			rpn_pkg::ST_EXEC: begin
				// pop two, push one: result lands where a was
				ram_we    = alu_wr;
				ram_waddr = cnt_m2[ADDR_W-1:0];
				ram_wdata = alu_res;
			end
			rpn_pkg::ST_DIVW: begin
				ram_we    = 1'b1;
				ram_wdata = quo_res;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	rpn_ram #(
		.WIDTH(DW),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == rpn_pkg::ST_IDLE && in_valid) begin
			ch_q   <= char_code;
			last_q <= last;
		end
		if (state_q == rpn_pkg::ST_RA) begin
			b_q <= ram_rdata;
		end
		if (state_q == rpn_pkg::ST_EXEC) begin
			div_quo_q <= a_mag;
			div_den_q <= b_mag;
			div_rem_q <= '0;
			div_neg_q <= ram_rdata[DW-1] ^ b_q[DW-1];
		end
		if (state_q == rpn_pkg::ST_DIV) begin
			div_rem_q <= div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
			div_quo_q <= {div_quo_q[DW-2:0], div_ge};
		end
		if (state_q == rpn_pkg::ST_FIN) begin
			val_q <= '0;
		end
		if (state_q == rpn_pkg::ST_FRD) begin
			val_q <= ram_rdata;
		end
		if (state_q == rpn_pkg::ST_EMIT && out_free) begin
			value_q  <= val_q;
			status_q <= err_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpn_pkg::ST_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			in_number_q <= 1'b0;
			err_q       <= rpn_pkg::STATUS_OK;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result enters the output register as the old one leaves
			if (state_q == rpn_pkg::ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rpn_pkg::ST_IDLE: begin
					if (in_valid) begin
						if (in_digit) begin
							acc_q       <= acc_nxt;
							in_number_q <= 1'b1;
							// a digit mid-number needs no stack work
							if (last) begin
								state_q <= rpn_pkg::ST_PUSH;
							end
						end else begin
							state_q <= rpn_pkg::ST_PUSH;
						end
					end
				end
				rpn_pkg::ST_PUSH: begin
					// finish a pending number
					if (in_number_q) begin
						acc_q       <= '0;
						in_number_q <= 1'b0;
						if (full && err_q == rpn_pkg::STATUS_OK) begin
							err_q <= rpn_pkg::STATUS_OVER;
						end
					end
					if (q_op && cnt_pu < CNT_W'(2)) begin
						// too few operands: stack empties
						cnt_q <= '0;
						if (err_q == rpn_pkg::STATUS_OK) begin
							err_q <= rpn_pkg::STATUS_UNDER;
						end
						state_q <= last_q ? rpn_pkg::ST_FIN : rpn_pkg::ST_IDLE;
					end else if (q_op) begin
						cnt_q   <= cnt_pu;
						state_q <= rpn_pkg::ST_RB;
					end else begin
						cnt_q   <= cnt_pu;
						state_q <= last_q ? rpn_pkg::ST_FIN : rpn_pkg::ST_IDLE;
					end
				end
				rpn_pkg::ST_RB: begin
					state_q <= rpn_pkg::ST_RA;
				end
				rpn_pkg::ST_RA: begin
					state_q <= rpn_pkg::ST_EXEC;
				end
				rpn_pkg::ST_EXEC: begin
					if (alu_wr) begin
						cnt_q   <= cnt_m1;
						state_q <= last_q ? rpn_pkg::ST_FIN : rpn_pkg::ST_IDLE;
					end else if (ch_q == rpn_pkg::CH_DIVIDE && b_q != '0) begin
						cnt_q     <= cnt_m2;
						div_cnt_q <= '0;
						state_q   <= rpn_pkg::ST_DIV;
					end else begin
						// divide by zero or an unknown operator: both operands dropped
						cnt_q <= cnt_m2;
						if (ch_q == rpn_pkg::CH_DIVIDE && err_q == rpn_pkg::STATUS_OK) begin
							err_q <= rpn_pkg::STATUS_DIVZERO;
						end
						state_q <= last_q ? rpn_pkg::ST_FIN : rpn_pkg::ST_IDLE;
					end
				end
				rpn_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						state_q <= rpn_pkg::ST_DIVW;
					end
				end
				rpn_pkg::ST_DIVW: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= last_q ? rpn_pkg::ST_FIN : rpn_pkg::ST_IDLE;
				end
				rpn_pkg::ST_FIN: begin
					if (cnt_q == '0) begin
						// empty stack gives zero and an underflow
						if (err_q == rpn_pkg::STATUS_OK) begin
							err_q <= rpn_pkg::STATUS_UNDER;
						end
						state_q <= rpn_pkg::ST_EMIT;
					end else begin
						state_q <= rpn_pkg::ST_FRD;
					end
				end
				rpn_pkg::ST_FRD: begin
					state_q <= rpn_pkg::ST_EMIT;
				end
				rpn_pkg::ST_EMIT: begin
					// wait for the output register, then start a fresh expression
					if (out_free) begin
						cnt_q       <= '0;
						err_q       <= rpn_pkg::STATUS_OK;
						state_q     <= rpn_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rpn_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != rpn_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpn_pkg::ST_DIV && div_cnt_q == 5'd31) |=> state_q == rpn_pkg::ST_DIVW)
		else $error("divider did not finish after 32 steps");

	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpn_pkg::ST_EMIT && out_free)
		|=> (out_valid_q && cnt_q == '0 && err_q == rpn_pkg::STATUS_OK))
		else $error("result transfer did not clear expression state");

	a_divzero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpn_pkg::ST_EXEC && ch_q == rpn_pkg::CH_DIVIDE && b_q == '0)
		|=> err_q != rpn_pkg::STATUS_OK)
		else $error("divide by zero not flagged");

endmodule

`default_nettype wire
